// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the print-job receiver.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pjrp_pkg.sv =====
// Types and constants of the print-job receiver.
// No dependencies; used by the receiver top level and the testbench.
`default_nettype none

package pjrp_pkg;

  // Protocol phases
  typedef enum logic [2:0] {
    PH_CMD        = 3'd0,
    PH_CMD_LINE   = 3'd1,
    PH_SUB        = 3'd2,
    PH_SUB_LINE   = 3'd3,
    PH_DATA       = 3'd4,
    PH_TRAILER    = 3'd5,
    PH_ERR_PEND   = 3'd6,
    PH_WAIT_CLOSE = 3'd7
  } phase_t;

  // Count parser steps
  typedef enum logic [1:0] {
    PS_SKIP   = 2'd0,
    PS_DIGITS = 2'd1,
    PS_DONE   = 2'd2
  } parse_step_t;

  // Result kinds
  localparam logic [1:0] KIND_RESP    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Response bytes and end causes
  localparam logic [7:0] RESP_ACK = 8'h00;
  localparam logic [7:0] RESP_NAK = 8'h01;
  localparam logic CAUSE_CLOSED = 1'b0;
  localparam logic CAUSE_PROTO  = 1'b1;

  // Command and subcommand codes
  localparam logic [7:0] CMD_RECEIVE_JOB = 8'h02;
  localparam logic [7:0] SUB_ABORT       = 8'h01;
  localparam logic [7:0] SUB_CONTROL     = 8'h02;
  localparam logic [7:0] SUB_DATA        = 8'h03;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Receive modes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_MULTI  = 2'd1;
  localparam logic [1:0] MODE_STREAM = 2'd2;

  // Configuration register indexes and port width
  localparam logic [1:0] REG_QUEUE_NAME   = 2'd0;
  localparam logic [1:0] REG_QUEUE_LENGTH = 2'd1;
  localparam logic [1:0] REG_RECEIVE_MODE = 2'd2;
  localparam int CFG_DATA_W = 64;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       cause;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pjrp_in_if.sv =====
// Input channel of the print-job receiver: one received byte or a close event.
// No dependencies.
`default_nettype none

interface pjrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       peer_closed;

  modport source (output valid, output in_byte, output peer_closed, input ready);
  modport sink   (input valid, input in_byte, input peer_closed, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pjrp_out_if.sv =====
// Result channel of the print-job receiver: response, payload or session end.
// No dependencies.
`default_nettype none

interface pjrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       end_cause;

  modport source (output valid, output out_kind, output out_byte, output end_cause,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input end_cause,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/print_job_receive_protocol_unit.sv =====
// Print-job receiver (server side of a line-printer receive exchange).
// Uses pjrp_pkg, pjrp_in_if, pjrp_out_if and assert_macros.svh.
//
// The block takes one received byte or one close event per item and gives at
// most one result per item: a response byte (ack/nak), a kept payload byte or
// a session end with its cause. It sustains one item per clock while the sink
// keeps taking results. An item is held in the input register, then the single
// state update loads the result register, which offers the result to the sink.
// The result register is released as soon as the sink takes it.
// While a finished result waits, the input register still takes one more item;
// further items wait until the sink takes the result. Configuration writes
// should only be made while no item is in flight.
`default_nettype none

module print_job_receive_protocol_unit #(
  parameter int COUNT_BITS  = 48,
  parameter int QUEUE_CHARS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [pjrp_pkg::CFG_DATA_W-1:0] cfg_data,
  pjrp_in_if.sink                            in_chan,
  pjrp_out_if.source                         out_chan
);

`include "assert_macros.svh"

  localparam int QN_W = 8 * QUEUE_CHARS;
  localparam int CW4  = COUNT_BITS + 4;
  localparam logic [3:0] QC4 = 4'(QUEUE_CHARS);

  // Configuration registers
  logic [QN_W-1:0] queue_name_r;
  logic [3:0]      queue_length_r;
  logic [1:0]      receive_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_name_r   <= '0;
      queue_length_r <= '0;
      receive_mode_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pjrp_pkg::REG_QUEUE_NAME:   queue_name_r   <= cfg_data[QN_W-1:0];
        pjrp_pkg::REG_QUEUE_LENGTH: queue_length_r <= cfg_data[3:0];
        pjrp_pkg::REG_RECEIVE_MODE: receive_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input register and stage handshake
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_closed_r;
  logic       out_vld_r;
  logic       go;

  assign go            = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r   <= in_chan.in_byte;
      in_closed_r <= in_chan.peer_closed;
    end
  end

  // Session state
  pjrp_pkg::phase_t      phase_r, phase_nxt;
  pjrp_pkg::parse_step_t step_r, step_nxt;
  logic [7:0]            cmd_r, cmd_nxt;
  logic [3:0]            name_idx_r, name_idx_nxt;
  logic                  name_mis_r, name_mis_nxt;
  logic                  name_end_r, name_end_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  count_neg_r, count_neg_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic                  until_close_r, until_close_nxt;
  logic                  keep_r, keep_nxt;
  logic                  first_pend_r, first_pend_nxt;

  // Shared decodes
  logic [7:0]      c;
  logic [3:0]      len_eff;
  logic [7:0]      want;
  logic            name_bad;
  logic            cnt_zero, cnt_neg, stream_mode, data_bad;
  logic            is_digit, is_ws;
  logic [CW4-1:0]  acc_ext;
  logic [CW4-1:0]  acc;
  logic [COUNT_BITS-1:0] acc_sat;

  assign c           = in_byte_r;
  assign len_eff     = (queue_length_r > QC4) ? QC4 : queue_length_r;
  assign name_bad    = (len_eff != 4'd0) && (name_mis_r || (name_idx_r != len_eff));
  assign cnt_zero    = (count_r == '0);
  assign cnt_neg     = count_neg_r && !cnt_zero;
  assign stream_mode = (receive_mode_r == pjrp_pkg::MODE_STREAM);
  assign data_bad    = stream_mode ? cnt_neg : (cnt_neg || cnt_zero);
  assign is_digit    = (c >= pjrp_pkg::CH_ZERO) && (c <= pjrp_pkg::CH_NINE);
  assign is_ws       = (c == pjrp_pkg::CH_SPACE) || (c == pjrp_pkg::CH_TAB) ||
                       (c == pjrp_pkg::CH_VT) || (c == pjrp_pkg::CH_FF) ||
                       (c == pjrp_pkg::CH_CR);

  // Configured character at the current name position
  always_comb begin
    want = '0;
    for (int i = 0; i < QUEUE_CHARS; i++) begin
      if (name_idx_r == 4'(i)) want = queue_name_r[i*8 +: 8];
    end
  end

  // Decimal accumulate: count*10 + digit, saturating at all ones
  assign acc_ext = {4'b0, count_r};
  assign acc     = (acc_ext << 3) + (acc_ext << 1) + CW4'(c - pjrp_pkg::CH_ZERO);
  assign acc_sat = (acc[CW4-1:COUNT_BITS] != 4'd0) ? '1 : acc[COUNT_BITS-1:0];

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    step_nxt        = step_r;
    cmd_nxt         = cmd_r;
    name_idx_nxt    = name_idx_r;
    name_mis_nxt    = name_mis_r;
    name_end_nxt    = name_end_r;
    count_nxt       = count_r;
    count_neg_nxt   = count_neg_r;
    left_nxt        = left_r;
    until_close_nxt = until_close_r;
    keep_nxt        = keep_r;
    first_pend_nxt  = first_pend_r;
    if (in_closed_r) begin
      // back to idle session
      phase_nxt       = pjrp_pkg::PH_CMD;
      step_nxt        = pjrp_pkg::PS_SKIP;
      cmd_nxt         = '0;
      name_idx_nxt    = '0;
      name_mis_nxt    = 1'b0;
      name_end_nxt    = 1'b0;
      count_nxt       = '0;
      count_neg_nxt   = 1'b0;
      left_nxt        = '0;
      until_close_nxt = 1'b0;
      keep_nxt        = 1'b0;
      first_pend_nxt  = 1'b1;
    end else begin
      case (phase_r)
        pjrp_pkg::PH_CMD, pjrp_pkg::PH_SUB: begin
          cmd_nxt       = c;
          name_idx_nxt  = '0;
          name_mis_nxt  = 1'b0;
          name_end_nxt  = 1'b0;
          count_nxt     = '0;
          count_neg_nxt = 1'b0;
          step_nxt      = pjrp_pkg::PS_SKIP;
          phase_nxt     = (phase_r == pjrp_pkg::PH_CMD) ? pjrp_pkg::PH_CMD_LINE
                                                        : pjrp_pkg::PH_SUB_LINE;
        end
        pjrp_pkg::PH_CMD_LINE: begin
          if (c != pjrp_pkg::CH_LF) begin
            // queue name compare, one character per item
            if (!name_end_r) begin
              if (c == pjrp_pkg::CH_SPACE || c == pjrp_pkg::CH_NUL) begin
                name_end_nxt = 1'b1;
              end else if (name_idx_r < len_eff) begin
                if (want != c) name_mis_nxt = 1'b1;
                name_idx_nxt = name_idx_r + 4'd1;
              end else begin
                name_mis_nxt = 1'b1;
              end
            end
          end else if (!name_bad && cmd_r == pjrp_pkg::CMD_RECEIVE_JOB) begin
            phase_nxt      = pjrp_pkg::PH_SUB;
            first_pend_nxt = 1'b1;
          end else begin
            phase_nxt = pjrp_pkg::PH_CMD;
          end
        end
        pjrp_pkg::PH_SUB_LINE: begin
          if (c != pjrp_pkg::CH_LF) begin
            // atoll-style count parse
            if (step_r == pjrp_pkg::PS_SKIP) begin
              if (is_ws) begin
                step_nxt = pjrp_pkg::PS_SKIP;
              end else if (c == pjrp_pkg::CH_PLUS || c == pjrp_pkg::CH_MINUS) begin
                count_neg_nxt = (c == pjrp_pkg::CH_MINUS);
                step_nxt      = pjrp_pkg::PS_DIGITS;
              end else if (is_digit) begin
                count_nxt = acc_sat;
                step_nxt  = pjrp_pkg::PS_DIGITS;
              end else begin
                step_nxt = pjrp_pkg::PS_DONE;
              end
            end else if (step_r == pjrp_pkg::PS_DIGITS) begin
              if (is_digit) count_nxt = acc_sat;
              else step_nxt = pjrp_pkg::PS_DONE;
            end
          end else begin
            case (cmd_r)
              pjrp_pkg::SUB_ABORT: phase_nxt = pjrp_pkg::PH_SUB;
              pjrp_pkg::SUB_CONTROL: begin
                keep_nxt        = 1'b0;
                until_close_nxt = cnt_neg;
                left_nxt        = cnt_neg ? '0 : count_r;
                phase_nxt       = (cnt_neg || !cnt_zero) ? pjrp_pkg::PH_DATA
                                                         : pjrp_pkg::PH_TRAILER;
              end
              pjrp_pkg::SUB_DATA: begin
                if (data_bad) begin
                  phase_nxt = pjrp_pkg::PH_ERR_PEND;
                end else begin
                  keep_nxt        = (receive_mode_r == pjrp_pkg::MODE_MULTI) || first_pend_r;
                  first_pend_nxt  = 1'b0;
                  until_close_nxt = stream_mode && cnt_zero;
                  left_nxt        = (stream_mode && cnt_zero) ? '0 : count_r;
                  // count is nonzero here unless streaming
                  phase_nxt       = pjrp_pkg::PH_DATA;
                end
              end
              default: phase_nxt = pjrp_pkg::PH_SUB;
            endcase
          end
        end
        pjrp_pkg::PH_DATA: begin
          if (!until_close_r) begin
            left_nxt = left_r - COUNT_BITS'(1);
            if (left_r == COUNT_BITS'(1)) phase_nxt = pjrp_pkg::PH_TRAILER;
          end
        end
        pjrp_pkg::PH_TRAILER: begin
          phase_nxt = (c == pjrp_pkg::CH_NUL) ? pjrp_pkg::PH_SUB : pjrp_pkg::PH_WAIT_CLOSE;
        end
        pjrp_pkg::PH_ERR_PEND: phase_nxt = pjrp_pkg::PH_WAIT_CLOSE;
        default: ;
      endcase
    end
  end

  // Result of the item in the input register
  pjrp_pkg::res_t res;
  logic           res_vld;

  always_comb begin
    res_vld   = 1'b0;
    res.kind  = pjrp_pkg::KIND_RESP;
    res.data  = pjrp_pkg::RESP_ACK;
    res.cause = pjrp_pkg::CAUSE_CLOSED;
    if (in_closed_r) begin
      if (phase_r != pjrp_pkg::PH_WAIT_CLOSE) begin
        res_vld   = 1'b1;
        res.kind  = pjrp_pkg::KIND_END;
        res.cause = (phase_r == pjrp_pkg::PH_ERR_PEND) ? pjrp_pkg::CAUSE_PROTO
                                                       : pjrp_pkg::CAUSE_CLOSED;
      end
    end else begin
      case (phase_r)
        pjrp_pkg::PH_CMD_LINE: begin
          if (c == pjrp_pkg::CH_LF) begin
            res_vld  = 1'b1;
            res.data = (!name_bad && cmd_r == pjrp_pkg::CMD_RECEIVE_JOB) ?
                       pjrp_pkg::RESP_ACK : pjrp_pkg::RESP_NAK;
          end
        end
        pjrp_pkg::PH_SUB_LINE: begin
          if (c == pjrp_pkg::CH_LF) begin
            res_vld = 1'b1;
            case (cmd_r)
              pjrp_pkg::SUB_ABORT, pjrp_pkg::SUB_CONTROL: res.data = pjrp_pkg::RESP_ACK;
              pjrp_pkg::SUB_DATA:
                res.data = data_bad ? pjrp_pkg::RESP_NAK : pjrp_pkg::RESP_ACK;
              default: res.data = pjrp_pkg::RESP_NAK;
            endcase
          end
        end
        pjrp_pkg::PH_DATA: begin
          if (keep_r) begin
            res_vld  = 1'b1;
            res.kind = pjrp_pkg::KIND_PAYLOAD;
            res.data = c;
          end
        end
        pjrp_pkg::PH_TRAILER: begin
          res_vld = 1'b1;
          if (c != pjrp_pkg::CH_NUL) begin
            res.kind  = pjrp_pkg::KIND_END;
            res.cause = pjrp_pkg::CAUSE_PROTO;
          end
        end
        pjrp_pkg::PH_ERR_PEND: begin
          res_vld   = 1'b1;
          res.kind  = pjrp_pkg::KIND_END;
          res.cause = pjrp_pkg::CAUSE_PROTO;
        end
        default: ;
      endcase
    end
  end

  // State registers, advanced once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= pjrp_pkg::PH_CMD;
      step_r        <= pjrp_pkg::PS_SKIP;
      cmd_r         <= '0;
      name_idx_r    <= '0;
      name_mis_r    <= 1'b0;
      name_end_r    <= 1'b0;
      count_r       <= '0;
      count_neg_r   <= 1'b0;
      left_r        <= '0;
      until_close_r <= 1'b0;
      keep_r        <= 1'b0;
      first_pend_r  <= 1'b1;
    end else if (go) begin
      phase_r       <= phase_nxt;
      step_r        <= step_nxt;
      cmd_r         <= cmd_nxt;
      name_idx_r    <= name_idx_nxt;
      name_mis_r    <= name_mis_nxt;
      name_end_r    <= name_end_nxt;
      count_r       <= count_nxt;
      count_neg_r   <= count_neg_nxt;
      left_r        <= left_nxt;
      until_close_r <= until_close_nxt;
      keep_r        <= keep_nxt;
      first_pend_r  <= first_pend_nxt;
    end
  end

  // Result register
  pjrp_pkg::res_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= res_vld;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld) out_r <= res;
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_kind  = out_r.kind;
  assign out_chan.out_byte  = out_r.data;
  assign out_chan.end_cause = out_r.cause;

  // Checks
  `ASSERT_IMP(a_count_left, phase_r == pjrp_pkg::PH_DATA && !until_close_r, left_r != '0, "counted transfer with nothing left")
  `ASSERT_NXT(a_close_resets, go && in_closed_r, phase_r == pjrp_pkg::PH_CMD && first_pend_r, "close did not restart the session")
  `ASSERT_IMP(a_end_byte, out_vld_r && out_r.kind == pjrp_pkg::KIND_END, out_r.data == pjrp_pkg::RESP_ACK, "session end carries a byte")

endmodule

`default_nettype wire

// ===== test/tb_print_job_receive_protocol_unit.sv =====
// Testbench for print_job_receive_protocol_unit: random print-job sessions, noise and broken
// exchanges, checked item by item against a behavioral predictor of the receiver.
// Depends on pjrp_pkg, pjrp_in_if, pjrp_out_if and the receiver RTL.

module tb_print_job_receive_protocol_unit;
  import pjrp_pkg::*;

  localparam int          COUNT_BITS   = 48;
  localparam int unsigned QUEUE_CHARS  = 8;
  localparam logic [63:0] COUNT_MAX    = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [1:0]  MODE_SPARE   = 2'd3;   // unassigned mode, behaves as single file
  localparam int          PHASE_HALF   = 50;     // least items queued per half phase
  localparam int          DRAIN_CYCLES = 6;
  localparam int          LONG_HOLD    = 300;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       closed;
  } rx_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pjrp_in_if  in_if ();
  pjrp_out_if out_if ();

  print_job_receive_protocol_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // Items waiting to be offered and replies still owed by the block
  rx_item_t wire_items[$];
  res_t     expected_replies[$];

  // Register mirrors
  logic [63:0] mirror_name;
  logic [3:0]  mirror_len;
  logic [1:0]  mirror_mode;

  // Predicted receiver state
  phase_t      job_phase;
  logic [7:0]  cmd_byte;
  int unsigned name_pos;
  bit          name_wrong;
  bit          name_done;
  logic [63:0] count_acc;
  bit          count_minus;
  parse_step_t count_step;
  logic [63:0] xfer_left;
  bit          xfer_to_close;
  bit          xfer_keep;
  bit          first_data_file;

  // Flow control knobs and bookkeeping
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_asked;
  int hold_seen;
  int hold_cycles;
  bit item_taken;
  int mismatches;
  int items_taken;
  int replies_seen;
  int sessions;
  int cycle_count;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_line();
    name_pos    = 0;
    name_wrong  = 1'b0;
    name_done   = 1'b0;
    count_acc   = '0;
    count_minus = 1'b0;
    count_step  = PS_SKIP;
  endfunction

  function automatic void clear_session();
    clear_line();
    job_phase       = PH_CMD;
    cmd_byte        = '0;
    xfer_left       = '0;
    xfer_to_close   = 1'b0;
    xfer_keep       = 1'b0;
    first_data_file = 1'b1;
  endfunction

  function automatic int unsigned eff_name_len();
    return (mirror_len > QUEUE_CHARS) ? QUEUE_CHARS : int'(mirror_len);
  endfunction

  function automatic void expect_reply(logic [1:0] kind, logic [7:0] data, logic cause);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.cause = cause;
    expected_replies.push_back(r);
  endfunction

  // Queue name ends at a space or a zero byte; configured characters compare literally
  function automatic void take_name_char(logic [7:0] c);
    if (name_done) return;
    if (c == CH_SPACE || c == CH_NUL) begin
      name_done = 1'b1;
    end else if (name_pos < eff_name_len()) begin
      if (mirror_name[8*name_pos +: 8] != c) name_wrong = 1'b1;
      name_pos++;
    end else begin
      name_wrong = 1'b1;
    end
  endfunction

  // Decimal count: blanks, one sign, digits; magnitude saturates
  function automatic void take_count_char(logic [7:0] c);
    logic [63:0] d;
    if (count_step == PS_SKIP) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        count_minus = (c == CH_MINUS);
        count_step  = PS_DIGITS;
        return;
      end
      count_step = PS_DIGITS;
    end
    if (count_step == PS_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = 64'(c - CH_ZERO);
        if (count_acc > (COUNT_MAX - d) / 64'd10) count_acc = COUNT_MAX;
        else count_acc = count_acc * 64'd10 + d;
      end else begin
        count_step = PS_DONE;
      end
    end
  endfunction

  function automatic void begin_transfer(bit keep, bit to_close);
    xfer_keep     = keep;
    xfer_to_close = to_close;
    xfer_left     = to_close ? 64'd0 : (count_acc & COUNT_MAX);
    job_phase     = (to_close || xfer_left != 0) ? PH_DATA : PH_TRAILER;
  endfunction

  function automatic void predict_reply(logic [7:0] c, logic closed);
    phase_t was;
    bit     zero;
    bit     neg;
    bit     streaming;
    if (closed) begin
      was = job_phase;
      clear_session();
      if (was == PH_ERR_PEND) expect_reply(KIND_END, 8'h00, CAUSE_PROTO);
      else if (was != PH_WAIT_CLOSE) expect_reply(KIND_END, 8'h00, CAUSE_CLOSED);
      return;
    end
    case (job_phase)
      PH_CMD: begin
        cmd_byte = c;
        clear_line();
        job_phase = PH_CMD_LINE;
      end
      PH_CMD_LINE: begin
        if (c != CH_LF) begin
          take_name_char(c);
        end else if (!(eff_name_len() != 0 && (name_wrong || name_pos != eff_name_len()))
                     && cmd_byte == CMD_RECEIVE_JOB) begin
          job_phase       = PH_SUB;
          first_data_file = 1'b1;
          expect_reply(KIND_RESP, RESP_ACK, 1'b0);
        end else begin
          job_phase = PH_CMD;
          expect_reply(KIND_RESP, RESP_NAK, 1'b0);
        end
      end
      PH_SUB: begin
        cmd_byte = c;
        clear_line();
        job_phase = PH_SUB_LINE;
      end
      PH_SUB_LINE: begin
        if (c != CH_LF) begin
          take_count_char(c);
        end else begin
          zero      = (count_acc == 0);
          neg       = count_minus && !zero;
          streaming = (mirror_mode == MODE_STREAM);
          if (cmd_byte == SUB_ABORT) begin
            job_phase = PH_SUB;
            expect_reply(KIND_RESP, RESP_ACK, 1'b0);
          end else if (cmd_byte == SUB_CONTROL) begin
            begin_transfer(1'b0, neg);
            expect_reply(KIND_RESP, RESP_ACK, 1'b0);
          end else if (cmd_byte == SUB_DATA) begin
            if (streaming ? neg : (neg || zero)) begin
              job_phase = PH_ERR_PEND;
              expect_reply(KIND_RESP, RESP_NAK, 1'b0);
            end else begin
              begin_transfer(mirror_mode == MODE_MULTI || first_data_file, streaming && zero);
              first_data_file = 1'b0;
              expect_reply(KIND_RESP, RESP_ACK, 1'b0);
            end
          end else begin
            job_phase = PH_SUB;
            expect_reply(KIND_RESP, RESP_NAK, 1'b0);
          end
        end
      end
      PH_DATA: begin
        if (!xfer_to_close) begin
          xfer_left = (xfer_left - 64'd1) & COUNT_MAX;
          if (xfer_left == 0) job_phase = PH_TRAILER;
        end
        if (xfer_keep) expect_reply(KIND_PAYLOAD, c, 1'b0);
      end
      PH_TRAILER: begin
        if (c == CH_NUL) begin
          job_phase = PH_SUB;
          expect_reply(KIND_RESP, RESP_ACK, 1'b0);
        end else begin
          job_phase = PH_WAIT_CLOSE;
          expect_reply(KIND_END, 8'h00, CAUSE_PROTO);
        end
      end
      PH_ERR_PEND: begin
        job_phase = PH_WAIT_CLOSE;
        expect_reply(KIND_END, 8'h00, CAUSE_PROTO);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_item(logic [7:0] b, logic cl);
    rx_item_t it;
    it.data   = b;
    it.closed = cl;
    wire_items.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endfunction

  // byte of a close event is don't-care, so randomize it
  function automatic void push_close();
    push_item(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void push_random_bytes(int n);
    for (int i = 0; i < n; i++) push_item(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // Bytes biased toward protocol codes, with the odd close
  function automatic void push_noise(int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       b = CH_NUL;
        1:       b = SUB_ABORT;
        2:       b = SUB_CONTROL;
        3:       b = SUB_DATA;
        4:       b = CH_LF;
        5:       b = CH_SPACE;
        6:       b = 8'($urandom_range(CH_ZERO, CH_NINE));
        default: b = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 29) == 0) push_close();
      else push_item(b, 1'b0);
    end
  endfunction

  function automatic logic [63:0] printable_name();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7e));
    return v;
  endfunction

  function automatic string count_text(longint n);
    string      s;
    logic [7:0] ch;
    s = "";
    for (int k = $urandom_range(0, 2); k > 0; k--) begin
      case ($urandom_range(0, 4))
        0:       ch = CH_SPACE;
        1:       ch = CH_TAB;
        2:       ch = CH_VT;
        3:       ch = CH_FF;
        default: ch = CH_CR;
      endcase
      s = $sformatf("%s%c", s, ch);
    end
    if (n < 0) s = {s, "-"};
    else if ($urandom_range(0, 3) == 0) s = {s, "+"};
    if ($urandom_range(0, 4) == 0) s = {s, "0"};
    s = $sformatf("%s%0d", s, (n < 0) ? -n : n);
    if ($urandom_range(0, 3) == 0) s = {s, " dfA042host"};
    return s;
  endfunction

  // Request line: queue name, optional tail after a space or a zero byte
  function automatic void push_queue_line(bit match);
    int unsigned len;
    len = eff_name_len();
    if (match) begin
      for (int i = 0; i < len; i++) push_item(mirror_name[8*i +: 8], 1'b0);
    end else begin
      case ($urandom_range(0, 2))
        0: for (int i = 1; i < len; i++) push_item(mirror_name[8*i +: 8], 1'b0);
        1: for (int i = 0; i <= len; i++) push_item(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
        default: begin
          for (int i = 0; i < len; i++) push_item(mirror_name[8*i +: 8], 1'b0);
          push_text("x");
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0: push_text(" root");
      1: begin
        push_item(CH_NUL, 1'b0);
        push_text("zz");
      end
      default: ;
    endcase
    push_item(CH_LF, 1'b0);
  endfunction

  // Counted file with its trailer; returns 1 when a bad trailer ended the session
  function automatic bit push_counted_file(logic [7:0] sub, int n);
    push_item(sub, 1'b0);
    push_text(count_text(n));
    push_item(CH_LF, 1'b0);
    push_random_bytes(n);
    if ($urandom_range(0, 15) != 0) begin
      push_item(CH_NUL, 1'b0);
      return 1'b0;
    end
    push_item(8'($urandom_range(1, 255)), 1'b0);
    push_random_bytes($urandom_range(0, 3));
    push_close();
    return 1'b1;
  endfunction

  function automatic void push_session();
    int     subs;
    int     pick;
    longint n;
    // now and then a refused request first
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        push_item(8'($urandom_range(0, 255)), 1'b0);
        push_queue_line(1'b1);
      end else begin
        push_item(CMD_RECEIVE_JOB, 1'b0);
        push_queue_line(1'b0);
      end
    end
    push_item(CMD_RECEIVE_JOB, 1'b0);
    push_queue_line(1'b1);
    subs = $urandom_range(1, 5);
    for (int k = 0; k < subs; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        push_item(SUB_ABORT, 1'b0);
        push_text(" job");
        push_item(CH_LF, 1'b0);
      end else if (pick < 35) begin
        if (push_counted_file(SUB_CONTROL, $urandom_range(0, 12))) return;
      end else if (pick < 70) begin
        n = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 16);
        if (push_counted_file(SUB_DATA, int'(n))) return;
      end else if (pick < 76) begin
        // transfer until close
        if (mirror_mode == MODE_STREAM && $urandom_range(0, 1) != 0) begin
          push_item(SUB_DATA, 1'b0);
          push_text(count_text(0));
        end else begin
          push_item(SUB_CONTROL, 1'b0);
          n = -longint'($urandom_range(1, 500));
          push_text(count_text(n));
        end
        push_item(CH_LF, 1'b0);
        push_random_bytes($urandom_range(0, 20));
        push_close();
        return;
      end else if (pick < 81) begin
        // unknown subcommand
        push_item(($urandom_range(0, 4) == 0) ? CH_NUL : 8'($urandom_range(4, 255)), 1'b0);
        push_text("7");
        push_item(CH_LF, 1'b0);
      end else if (pick < 87) begin
        // rejected data count, then protocol error
        push_item(SUB_DATA, 1'b0);
        if (mirror_mode != MODE_STREAM && $urandom_range(0, 1) != 0) n = 0;
        else n = -longint'($urandom_range(1, 99));
        push_text(count_text(n));
        push_item(CH_LF, 1'b0);
        if ($urandom_range(0, 3) != 0) push_random_bytes($urandom_range(1, 3));
        push_close();
        return;
      end else if (pick < 91) begin
        // extreme counts, cut off by a close
        push_item(($urandom_range(0, 1) != 0) ? SUB_DATA : SUB_CONTROL, 1'b0);
        case ($urandom_range(0, 2))
          0:       push_text("99999999999999999999999");
          1:       push_text("281474976710655");
          default: push_text("-0");
        endcase
        push_item(CH_LF, 1'b0);
        push_random_bytes($urandom_range(0, 6));
        push_close();
        return;
      end else begin
        push_noise($urandom_range(1, 6));
      end
    end
    push_close();
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_reply(logic [1:0] kind, logic [7:0] data, logic cause);
    res_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h cause %0d",
                                kind, data, cause));
    end else begin
      want = expected_replies.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
      if (data !== want.data)
        report_mismatch($sformatf("byte %02h, predicted %02h", data, want.data));
      if (cause !== want.cause)
        report_mismatch($sformatf("cause %0d, predicted %0d", cause, want.cause));
    end
  endtask

  // ---------------------------------------------------------------- clock and processes

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor: check results first, then predict from the item taken at this edge
  always @(posedge clk) begin
    item_taken = 1'b0;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        replies_seen++;
        check_reply(out_if.out_kind, out_if.out_byte, out_if.end_cause);
      end
      if (in_if.valid && in_if.ready) begin
        item_taken = 1'b1;
        items_taken++;
        predict_reply(in_if.in_byte, in_if.peer_closed);
        void'(wire_items.pop_front());
      end
    end
  end

  // Sender: hold an offered item until taken, otherwise offer the next or idle
  always @(negedge clk) begin
    if (rst_n && !(in_if.valid && !item_taken)) begin
      if (wire_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= wire_items[0].data;
        in_if.peer_closed <= wire_items[0].closed;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
        hold_seen   = hold_asked;
        hold_cycles = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_QUEUE_NAME:   mirror_name = val;
      REG_QUEUE_LENGTH: mirror_len  = val[3:0];
      REG_RECEIVE_MODE: mirror_mode = val[1:0];
      default: ;
    endcase
  endtask

  // Wait for every item taken and every result in, then let items without results settle
  task automatic wait_idle();
    while (wire_items.size() != 0 || expected_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [63:0] nm;
    logic [3:0]  ln;
    logic [1:0]  md;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_QUEUE_NAME;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.in_byte     = 8'h00;
    in_if.peer_closed = 1'b0;
    out_if.ready      = 1'b0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    hold_asked        = 0;
    hold_seen         = 0;
    hold_cycles       = 0;
    item_taken        = 1'b0;
    mismatches        = 0;
    items_taken       = 0;
    replies_seen      = 0;
    sessions          = 0;
    cycle_count       = 0;
    mirror_name       = '0;
    mirror_len        = '0;
    mirror_mode       = MODE_SINGLE;
    clear_session();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: any queue, single-file mode
    write_reg(REG_QUEUE_NAME, 64'h706c);
    write_reg(REG_QUEUE_LENGTH, 64'd0);
    write_reg(REG_RECEIVE_MODE, 64'(MODE_SINGLE));
    push_item(CMD_RECEIVE_JOB, 1'b0);             // request with a tail after the name
    push_text("a b");
    push_item(CH_LF, 1'b0);
    push_item(SUB_ABORT, 1'b0);                   // abort is acked
    push_item(CH_LF, 1'b0);
    push_item(8'h07, 1'b0);                       // unknown subcommand is naked
    push_item(CH_LF, 1'b0);
    push_item(SUB_DATA, 1'b0);                    // data file, signed count with junk
    push_text(" +2x");
    push_item(CH_LF, 1'b0);
    push_item(8'hff, 1'b0);                       // payload extremes
    push_item(8'h00, 1'b0);
    push_item(CH_NUL, 1'b0);                      // good trailer
    push_item(SUB_CONTROL, 1'b0);                 // control file with a bad trailer
    push_text("1");
    push_item(CH_LF, 1'b0);
    push_item(8'h5a, 1'b0);
    push_item(8'h05, 1'b0);
    push_item(8'h41, 1'b0);                       // ignored while waiting for close
    push_close();
    wait_idle();

    // Random phases, each with its own settings and flow control
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      case (p)
        0: begin nm = printable_name();           ln = 4'd15; md = MODE_SINGLE; end
        1: begin nm = 64'h706c;                   ln = 4'd2;  md = MODE_MULTI;  end
        2: begin nm = printable_name();           ln = 4'd0;  md = MODE_STREAM; end
        3: begin nm = 64'hffff_ffff_ffff_ffff;    ln = 4'd8;  md = MODE_SPARE;  end
        4: begin nm = 64'h0;                      ln = 4'd0;  md = MODE_STREAM; end
        5: begin nm = printable_name();           ln = 4'd3;  md = MODE_MULTI;  end
        6: begin nm = {$urandom, $urandom};       ln = 4'd9;  md = MODE_SINGLE; end
        default: begin nm = printable_name();     ln = 4'd5;  md = MODE_STREAM; end
      endcase
      write_reg(REG_QUEUE_NAME, nm);
      write_reg(REG_QUEUE_LENGTH, 64'(ln));
      write_reg(REG_RECEIVE_MODE, 64'(md));
      // long receiver hold while the sender keeps offering
      if (p % 4 == 0) hold_asked++;
      // two halves; the sender pauses in between until all results are in
      repeat (2) begin
        while (wire_items.size() < PHASE_HALF) begin
          if ($urandom_range(0, 9) == 0) push_noise($urandom_range(10, 30));
          else push_session();
          sessions++;
        end
        wait_idle();
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
    $display("Run covered %0d input items and %0d results in %0d sessions or noise bursts,",
             items_taken, replies_seen, sessions);
    $display("over nine register settings and four flow-control mixes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
